// ===== rtl/core/tmr_pkg.sv =====
// Package for the handheld console timer: item opcodes, register addresses,
// the timer state record and the divider tap masks. No dependencies.
package tmr_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } tmr_op_t;

  localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
  localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
  localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
  localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

  localparam logic [7:0] CONTROL_FILL = 8'hF8;
  localparam logic [7:0] UNMAPPED     = 8'hFF;

  localparam logic [15:0] AUDIO_BIT_NORMAL = 16'd8192;
  localparam logic [15:0] AUDIO_BIT_DOUBLE = 16'd16384;

  typedef struct packed {
    logic [15:0] div;
    logic [7:0]  cnt;
    logic [7:0]  tma;
    logic [1:0]  mode;
    logic        en;
    logic        tedge;
    logic        aedge;
  } tmr_state_t;

  // Divider tap for each rate mode.
  function automatic logic [15:0] mode_mask(input logic [1:0] mode);
    logic [15:0] m;
    case (mode)
      2'd0:    m = 16'd512;
      2'd1:    m = 16'd8;
      2'd2:    m = 16'd32;
      2'd3:    m = 16'd128;
      default: m = 16'd512;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/tmr_sub_step.sv =====
// One divider increment with counter and audio edge detection.
// Depends on tmr_pkg.
module tmr_sub_step
  import tmr_pkg::*;
(
  input  tmr_state_t st_i,
  input  logic       dbl_i,
  output tmr_state_t st_o,
  output logic       irq_o,
  output logic       pulse_o
);

  logic [15:0] div_inc;
  logic [7:0]  cnt_inc;
  logic        t_level;
  logic        a_level;

  always_comb begin
    div_inc = st_i.div + 16'd1;
    cnt_inc = st_i.cnt + 8'd1;
    t_level = |(div_inc & mode_mask(st_i.mode));
    a_level = |(div_inc & (dbl_i ? AUDIO_BIT_DOUBLE : AUDIO_BIT_NORMAL));
    st_o     = st_i;
    st_o.div = div_inc;
    irq_o    = 1'b0;
    if (st_i.en) begin
      if (t_level && !st_i.tedge) begin
        if (cnt_inc == 8'd0) begin
          st_o.cnt = st_i.tma;
          irq_o    = 1'b1;
        end else begin
          st_o.cnt = cnt_inc;
        end
      end
      st_o.tedge = t_level;
    end
    pulse_o    = a_level && !st_i.aedge;
    st_o.aedge = a_level;
  end

endmodule

// ===== rtl/core/tmr_core.sv =====
// Next-state and result logic for one item: ticks, reads and writes.
// Depends on tmr_pkg and tmr_sub_step.
module tmr_core
  import tmr_pkg::*;
(
  input  tmr_op_t     op_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  wdata_i,
  input  logic        dbl_i,
  input  logic        stop_i,
  input  tmr_state_t  st_i,
  output tmr_state_t  st_o,
  output logic [7:0]  rdata_o,
  output logic        irq_o,
  output logic        pulse_o
);

  tmr_state_t st_a;
  tmr_state_t st_b;
  logic       irq_a;
  logic       irq_b;
  logic       pulse_a;
  logic       pulse_b;

  tmr_sub_step u_step_a (
    .st_i   (st_i),
    .dbl_i  (dbl_i),
    .st_o   (st_a),
    .irq_o  (irq_a),
    .pulse_o(pulse_a)
  );

  tmr_sub_step u_step_b (
    .st_i   (st_a),
    .dbl_i  (dbl_i),
    .st_o   (st_b),
    .irq_o  (irq_b),
    .pulse_o(pulse_b)
  );

  always_comb begin
    st_o    = st_i;
    rdata_o = 8'd0;
    irq_o   = 1'b0;
    pulse_o = 1'b0;
    case (op_i)
      OP_TICK: begin
        if (!stop_i) begin
          if (dbl_i) begin
            st_o    = st_b;
            irq_o   = irq_a | irq_b;
            pulse_o = pulse_a | pulse_b;
          end else begin
            st_o    = st_a;
            irq_o   = irq_a;
            pulse_o = pulse_a;
          end
        end
      end
      OP_READ: begin
        case (addr_i)
          ADDR_CONTROL: rdata_o = CONTROL_FILL | {5'd0, st_i.en, st_i.mode};
          ADDR_COUNTER: rdata_o = st_i.cnt;
          ADDR_DIVIDER: rdata_o = st_i.div[15:8];
          ADDR_MODULO:  rdata_o = st_i.tma;
          default:      rdata_o = UNMAPPED;
        endcase
      end
      OP_WRITE: begin
        case (addr_i)
          ADDR_CONTROL: begin
            st_o.mode = wdata_i[1:0];
            st_o.en   = wdata_i[2];
          end
          ADDR_COUNTER: st_o.cnt = wdata_i;
          ADDR_DIVIDER: st_o.div = 16'd0;
          ADDR_MODULO:  st_o.tma = wdata_i;
          default:      st_o = st_i;
        endcase
      end
      default: st_o = st_i;
    endcase
  end

endmodule

// ===== rtl/core/handheld_console_timer.sv =====
// Top level of the handheld console timer: input word register, timer
// state, result register and handshake. Depends on tmr_pkg and tmr_core.
//
// Usage. Every input word is one machine cycle of the bus: a tick, a
// register read or a register write, selected by in_tuser. Each word gives
// exactly one result word carrying the read byte and the interrupt and
// audio pulse flags of that cycle.
// An accepted word is held in the input register, then the timer logic (up to
// two divider increments in double speed, chained combinationally) writes
// the state and the result register together when the word moves on, and
// out_tvalid rises with the result. Throughput is one word per cycle while the
// receiver keeps out_tready high; the rate is set by the single state update
// per cycle in the timer logic.
// Reset (rst_n low, synchronous) clears the divider, counter, modulo,
// control and edge memories and empties both register stages.
// When the receiver holds out_tready low, the result stays in the output
// register and the input register keeps one more word; in_tready then
// drops until the result is taken, so no word is lost or repeated.
module handheld_console_timer
  import tmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // bit 15:0 address, 23:16 write_data, 24 double_speed, 25 cpu_stopped,
  // 31:26 zero
  input  logic [31:0] in_tdata,
  // bit 1:0 opcode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bit 7:0 read_data, 8 timer_interrupt, 9 audio_pulse, 15:10 zero
  output logic [15:0] out_tdata
);

  // Input word register.
  logic        in_valid_r;
  tmr_op_t     op_r;
  logic [15:0] addr_r;
  logic [7:0]  wdata_r;
  logic        dbl_r;
  logic        stop_r;

  // Timer state and result register.
  tmr_state_t  st_r;
  tmr_state_t  st_nxt;
  logic        out_valid_r;
  logic [7:0]  rdata_r;
  logic        irq_r;
  logic        pulse_r;
  logic [7:0]  rdata_nxt;
  logic        irq_nxt;
  logic        pulse_nxt;

  logic        advance;
  logic        in_fire;

  // The held word moves on when the result register is empty or is being
  // emptied in this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  tmr_core u_core (
    .op_i   (op_r),
    .addr_i (addr_r),
    .wdata_i(wdata_r),
    .dbl_i  (dbl_r),
    .stop_i (stop_r),
    .st_i   (st_r),
    .st_o   (st_nxt),
    .rdata_o(rdata_nxt),
    .irq_o  (irq_nxt),
    .pulse_o(pulse_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= tmr_op_t'(in_tuser);
      addr_r  <= in_tdata[15:0];
      wdata_r <= in_tdata[23:16];
      dbl_r   <= in_tdata[24];
      stop_r  <= in_tdata[25];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rdata_r <= rdata_nxt;
      irq_r   <= irq_nxt;
      pulse_r <= pulse_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, pulse_r, irq_r, rdata_r};

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

  // Flags are raised only by ticks, which never return read data.
  a_flags_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (irq_nxt || pulse_nxt) |-> op_r == OP_TICK && rdata_nxt == 8'd0)
    else $error("flag raised by a non-tick word");

  // A divider write leaves the divider cleared.
  a_div_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && op_r == OP_WRITE && addr_r == ADDR_DIVIDER |=> st_r.div == 16'd0)
    else $error("divider not cleared by write");

  // State only changes when a word is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r))
    else $error("timer state changed without a word");

endmodule
